### rtl/b32e_pkg.sv
// ----------------------------------------------------------------------------
// Bech32 encoder package
// Shared types, constants and checksum helpers for the Bech32 string encoder.
// ----------------------------------------------------------------------------
package b32e_pkg;

  localparam int unsigned PrefixDepth = 64;

  typedef enum logic [1:0] {
    OP_PREFIX = 2'd0,
    OP_DATA   = 2'd1,
    OP_FINISH = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  typedef struct packed {
    op_e        kind;
    logic       do_sep;
    logic [7:0] value;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREFIX,
    ST_SEP_START,
    ST_REPLAY,
    ST_SEP_EMIT,
    ST_DATA_SYM0,
    ST_DATA_SYM1,
    ST_PAD,
    ST_CHK_FEED,
    ST_CHK_OUT
  } state_e;

  localparam logic [4:0][29:0] Gen = {
    30'h2a1462b3, 30'h3d4233dd, 30'h1ea119fa, 30'h26508e6d, 30'h3b6a57b2
  };

  localparam logic [255:0] Charset = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  localparam logic [7:0] SepChar = 8'h31;

  localparam logic [29:0] PolymodInit = 30'd1;

  function automatic logic [29:0] polymod_feed(logic [29:0] pm, logic [4:0] v);
    logic [29:0] r;
    logic [4:0]  top;
    top = pm[29:25];
    r   = {pm[24:0], v};
    for (int k = 0; k < 5; k++) begin
      if (top[k]) begin
        r = r ^ Gen[k];
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] sym_char(logic [4:0] s);
    logic [4:0] idx;
    idx = 5'd31 - s;
    return Charset[{idx, 3'b000} +: 8];
  endfunction

endpackage

### rtl/b32e_ifs.sv
// ----------------------------------------------------------------------------
// Bech32 encoder channels
// Valid/ready channel interfaces for the request and result streams.
// ----------------------------------------------------------------------------
interface b32e_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] byte_value;

  modport source (output valid, output operation, output byte_value, input ready);
  modport sink   (input valid, input operation, input byte_value, output ready);
endinterface

interface b32e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_of_run;
  logic       end_of_string;

  modport source (output valid, output out_char, output last_of_run,
                  output end_of_string, input ready);
  modport sink   (input valid, input out_char, input last_of_run,
                  input end_of_string, output ready);
endinterface

### rtl/b32e_queue.sv
// ----------------------------------------------------------------------------
// Bech32 encoder command queue
// Two-entry FIFO between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module b32e_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b32e_pkg::cmd_t  cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output b32e_pkg::cmd_t  cmd_o
);

  b32e_pkg::cmd_t entry_q [2];
  logic           wptr_q, wptr_d;
  logic           rptr_q, rptr_d;
  logic [1:0]     count_q, count_d;
  logic           do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign cmd_o   = entry_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d  = do_push ? ~wptr_q : wptr_q;
    rptr_d  = do_pop  ? ~rptr_q : rptr_q;
    count_d = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= cmd_i;
    end
  end

endmodule

### rtl/b32e_front.sv
// ----------------------------------------------------------------------------
// Bech32 encoder front end
// Accepts requests, drops ignored ones and tags where the separator goes.
// ----------------------------------------------------------------------------
module b32e_front #(
  parameter int unsigned PREFIX_DEPTH = b32e_pkg::PrefixDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  b32e_in_if.sink         in_i,
  output logic            push_o,
  output b32e_pkg::cmd_t  cmd_o,
  input  logic            full_i
);

  localparam int unsigned LenW = $clog2(PREFIX_DEPTH + 1);

  logic            sep_q, sep_d;
  logic [LenW-1:0] len_q, len_d;
  logic            accept;
  b32e_pkg::op_e   op;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign op         = b32e_pkg::op_e'(in_i.operation);

  always_comb begin
    sep_d        = sep_q;
    len_d        = len_q;
    push_o       = 1'b0;
    cmd_o.kind   = op;
    cmd_o.do_sep = !sep_q;
    cmd_o.value  = in_i.byte_value;
    if (accept) begin
      case (op)
        b32e_pkg::OP_PREFIX: begin
          if (!sep_q && (len_q < LenW'(PREFIX_DEPTH))) begin
            push_o = 1'b1;
            len_d  = len_q + 1'b1;
          end
        end
        b32e_pkg::OP_DATA: begin
          push_o = 1'b1;
          sep_d  = 1'b1;
        end
        b32e_pkg::OP_FINISH: begin
          push_o = 1'b1;
          sep_d  = 1'b0;
          len_d  = '0;
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= 1'b0;
      len_q <= '0;
    end else begin
      sep_q <= sep_d;
      len_q <= len_d;
    end
  end

endmodule

### rtl/b32e_back.sv
// ----------------------------------------------------------------------------
// Bech32 encoder back end
// Sequencer that runs the checksum, prefix replay and character output.
// ----------------------------------------------------------------------------
module b32e_back #(
  parameter int unsigned PREFIX_DEPTH = b32e_pkg::PrefixDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  b32e_pkg::cmd_t  cmd_i,
  output logic            pop_o,
  b32e_out_if.source      out_o
);

  localparam int unsigned LenW = $clog2(PREFIX_DEPTH + 1);
  localparam int unsigned IdxW = (PREFIX_DEPTH > 1) ? $clog2(PREFIX_DEPTH) : 1;

  b32e_pkg::state_e state_q, state_d;
  b32e_pkg::cmd_t   cmd_q;
  logic [29:0]      pm_q, pm_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  idx_q, idx_d;
  logic             rd_valid_q, rd_valid_d;
  logic [3:0]       acc_q, acc_d;
  logic [2:0]       bh_q, bh_d;
  logic [2:0]       cnt_q, cnt_d;

  logic [4:0]       mem [PREFIX_DEPTH];
  logic [4:0]       rd_data_q;
  logic             rd_en, wr_en;
  logic [IdxW-1:0]  rd_addr;

  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_char_q;
  logic             out_last_q, out_eos_q;
  logic             emit_req, emit_last, emit_eos, load;
  logic [7:0]       emit_char;

  logic [11:0]      comb;
  logic [3:0]       nb;
  logic             two_syms;
  logic [4:0]       sym0, sym1, pad_sym;
  logic [2:0]       rem;
  logic [3:0]       new_acc;
  logic [11:0]      rem_mask;

  always_comb begin
    comb     = {acc_q, cmd_q.value};
    nb       = {1'b0, bh_q} + 4'd8;
    two_syms = (nb >= 4'd10);
    sym0     = 5'(comb >> (nb - 4'd5));
    sym1     = 5'(comb >> (nb - 4'd10));
    rem      = two_syms ? 3'(nb - 4'd10) : 3'(nb - 4'd5);
    rem_mask = (12'd1 << rem) - 12'd1;
    new_acc  = 4'(comb & rem_mask);
    pad_sym  = 5'({1'b0, acc_q} << (3'd5 - bh_q));
  end

  assign load = emit_req && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d    = state_q;
    pm_d       = pm_q;
    len_d      = len_q;
    idx_d      = idx_q;
    rd_valid_d = rd_valid_q;
    acc_d      = acc_q;
    bh_d       = bh_q;
    cnt_d      = cnt_q;
    pop_o      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = idx_q[IdxW-1:0];
    wr_en      = 1'b0;
    emit_req   = 1'b0;
    emit_char  = cmd_q.value;
    emit_last  = 1'b0;
    emit_eos   = 1'b0;
    case (state_q)
      b32e_pkg::ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (cmd_i.kind == b32e_pkg::OP_PREFIX) begin
            state_d = b32e_pkg::ST_PREFIX;
          end else if (cmd_i.do_sep) begin
            state_d = b32e_pkg::ST_SEP_START;
          end else if (cmd_i.kind == b32e_pkg::OP_DATA) begin
            state_d = b32e_pkg::ST_DATA_SYM0;
          end else if (bh_q != 3'd0) begin
            state_d = b32e_pkg::ST_PAD;
          end else begin
            state_d = b32e_pkg::ST_CHK_FEED;
          end
        end
      end
      b32e_pkg::ST_PREFIX: begin
        emit_req  = 1'b1;
        emit_char = cmd_q.value;
        emit_last = 1'b1;
        if (load) begin
          wr_en   = 1'b1;
          pm_d    = b32e_pkg::polymod_feed(pm_q, {2'b00, cmd_q.value[7:5]});
          len_d   = len_q + 1'b1;
          state_d = b32e_pkg::ST_IDLE;
        end
      end
      b32e_pkg::ST_SEP_START: begin
        pm_d       = b32e_pkg::polymod_feed(pm_q, 5'd0);
        rd_en      = 1'b1;
        rd_addr    = '0;
        rd_valid_d = (len_q != '0);
        idx_d      = LenW'(1);
        state_d    = b32e_pkg::ST_REPLAY;
      end
      b32e_pkg::ST_REPLAY: begin
        if (rd_valid_q) begin
          pm_d       = b32e_pkg::polymod_feed(pm_q, rd_data_q);
          rd_en      = (idx_q < len_q);
          rd_valid_d = (idx_q < len_q);
          if (idx_q < len_q) begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          state_d = b32e_pkg::ST_SEP_EMIT;
        end
      end
      b32e_pkg::ST_SEP_EMIT: begin
        emit_req  = 1'b1;
        emit_char = b32e_pkg::SepChar;
        if (load) begin
          if (cmd_q.kind == b32e_pkg::OP_DATA) begin
            state_d = b32e_pkg::ST_DATA_SYM0;
          end else if (bh_q != 3'd0) begin
            state_d = b32e_pkg::ST_PAD;
          end else begin
            state_d = b32e_pkg::ST_CHK_FEED;
          end
        end
      end
      b32e_pkg::ST_DATA_SYM0: begin
        emit_req  = 1'b1;
        emit_char = b32e_pkg::sym_char(sym0);
        emit_last = !two_syms;
        if (load) begin
          pm_d = b32e_pkg::polymod_feed(pm_q, sym0);
          if (two_syms) begin
            state_d = b32e_pkg::ST_DATA_SYM1;
          end else begin
            acc_d   = new_acc;
            bh_d    = rem;
            state_d = b32e_pkg::ST_IDLE;
          end
        end
      end
      b32e_pkg::ST_DATA_SYM1: begin
        emit_req  = 1'b1;
        emit_char = b32e_pkg::sym_char(sym1);
        emit_last = 1'b1;
        if (load) begin
          pm_d    = b32e_pkg::polymod_feed(pm_q, sym1);
          acc_d   = new_acc;
          bh_d    = rem;
          state_d = b32e_pkg::ST_IDLE;
        end
      end
      b32e_pkg::ST_PAD: begin
        emit_req  = 1'b1;
        emit_char = b32e_pkg::sym_char(pad_sym);
        if (load) begin
          pm_d    = b32e_pkg::polymod_feed(pm_q, pad_sym);
          cnt_d   = 3'd0;
          state_d = b32e_pkg::ST_CHK_FEED;
        end
      end
      b32e_pkg::ST_CHK_FEED: begin
        pm_d  = b32e_pkg::polymod_feed(pm_q, 5'd0);
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd5) begin
          pm_d    = b32e_pkg::polymod_feed(pm_q, 5'd0) ^ 30'd1;
          cnt_d   = 3'd0;
          state_d = b32e_pkg::ST_CHK_OUT;
        end
      end
      b32e_pkg::ST_CHK_OUT: begin
        emit_req  = 1'b1;
        emit_char = b32e_pkg::sym_char(pm_q[29:25]);
        emit_last = (cnt_q == 3'd5);
        emit_eos  = (cnt_q == 3'd5);
        if (load) begin
          pm_d  = {pm_q[24:0], 5'd0};
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == 3'd5) begin
            pm_d    = b32e_pkg::PolymodInit;
            len_d   = '0;
            acc_d   = 4'd0;
            bh_d    = 3'd0;
            cnt_d   = 3'd0;
            state_d = b32e_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = b32e_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= b32e_pkg::ST_IDLE;
      pm_q        <= b32e_pkg::PolymodInit;
      len_q       <= '0;
      idx_q       <= '0;
      rd_valid_q  <= 1'b0;
      acc_q       <= 4'd0;
      bh_q        <= 3'd0;
      cnt_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pm_q        <= pm_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      rd_valid_q  <= rd_valid_d;
      acc_q       <= acc_d;
      bh_q        <= bh_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
    if (load) begin
      out_char_q <= emit_char;
      out_last_q <= emit_last;
      out_eos_q  <= emit_eos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[len_q[IdxW-1:0]] <= cmd_q.value[4:0];
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_char      = out_char_q;
  assign out_o.last_of_run   = out_last_q;
  assign out_o.end_of_string = out_eos_q;

endmodule

### rtl/bech32_string_encoder.sv
// The first character of a request passes through the command queue, the sequencer's
// command register and the output register. The sequencer finishes each command
// before it pops the next, while the queue keeps accepting requests until full.
// Separator: one stored prefix entry read per cycle, replayed into the checksum.
// Finish: up to 1 pad + 6 checksum steps + 6 characters. No clearing pass after reset.
// ----------------------------------------------------------------------------
// Bech32 string encoder
// Builds a Bech32 string with its checksum from prefix, data and finish requests.
// ----------------------------------------------------------------------------
module bech32_string_encoder #(
  parameter int unsigned PREFIX_DEPTH = b32e_pkg::PrefixDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  b32e_in_if.sink     in_i,
  b32e_out_if.source  out_o
);

  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  b32e_pkg::cmd_t front_cmd;
  b32e_pkg::cmd_t head_cmd;

  b32e_front #(
    .PREFIX_DEPTH (PREFIX_DEPTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_o (push),
    .cmd_o  (front_cmd),
    .full_i (full)
  );

  b32e_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (head_cmd)
  );

  b32e_back #(
    .PREFIX_DEPTH (PREFIX_DEPTH)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .cmd_i   (head_cmd),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
